// ===== hdl/s256h_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s256h_pkg;

    // Schedule memory geometry
    localparam int WordW    = 32;
    localparam int RamDepth = 16;
    localparam int RamAw    = 4;
    localparam int Rounds   = 64;

    // Padding and block constants
    localparam logic [7:0] PadByte       = 8'h80;
    localparam logic [5:0] TwoBlockCount = 6'd56;
    localparam logic [5:0] LastByteSlot  = 6'd63;
    localparam logic [5:0] LastRound     = 6'd63;
    localparam logic [3:0] LastWordSlot  = 4'd15;
    localparam logic [3:0] LenHiSlot     = 4'd14;
    localparam logic [2:0] LastDigest    = 3'd7;

    // Round constants
    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash values
    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_CSTART,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    // Controls from the sequencer to the compression datapath
    typedef struct packed {
        logic init;  // hash state back to initial values
        logic load;  // working variables from hash state
        logic step;  // one round
        logic fold;  // hash state += working variables
    } t_core_ctl;

endpackage

`default_nettype wire

// ===== hdl/s256h_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s256h_ram (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [s256h_pkg::RamAw-1:0]    i_waddr,
    input  wire logic [s256h_pkg::WordW-1:0]    i_wdata,
    input  wire logic [s256h_pkg::RamAw-1:0]    i_raddr_a,
    input  wire logic [s256h_pkg::RamAw-1:0]    i_raddr_b,
    output logic      [s256h_pkg::WordW-1:0]    o_rdata_a,
    output logic      [s256h_pkg::WordW-1:0]    o_rdata_b
);
    import s256h_pkg::*;

    // Block words and rolling message schedule
    logic [WordW-1:0] r_mem [RamDepth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== hdl/s256h_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s256h_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire s256h_pkg::t_core_ctl        i_ctl,
    input  wire logic [5:0]                  i_round,
    input  wire logic [s256h_pkg::WordW-1:0] i_rd_a,
    input  wire logic [s256h_pkg::WordW-1:0] i_rd_b,
    input  wire logic [2:0]                  i_word_sel,
    output logic      [s256h_pkg::WordW-1:0] o_sched_word,
    output logic      [s256h_pkg::WordW-1:0] o_digest_word
);
    import s256h_pkg::*;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] r_h  [8];   // chaining value
    logic [31:0] r_v  [8];   // working variables a..h
    logic [31:0] r_wl [7];   // last seven schedule words, newest first

    logic [31:0] w, s0, s1, t1, t2, big_s0, big_s1, ch, maj;

    // Schedule word: block word for the first sixteen rounds, then expanded.
    // rd_a holds w[r-16], rd_b holds w[r-15].
    always_comb begin
        s0 = ror(i_rd_b, 7) ^ ror(i_rd_b, 18) ^ (i_rd_b >> 3);
        s1 = ror(r_wl[1], 17) ^ ror(r_wl[1], 19) ^ (r_wl[1] >> 10);
        if (i_round < 6'd16) begin
            w = i_rd_a;
        end else begin
            w = s1 + r_wl[6] + s0 + i_rd_a;
        end
    end

    // Round function
    always_comb begin
        big_s1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big_s0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_s1 + ch + RoundK[i_round] + w;
        t2     = big_s0 + maj;
    end

    // Chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= InitH[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    // Working variables and schedule taps
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctl.step) begin
            r_wl[0] <= w;
            for (int i = 1; i < 7; i++) r_wl[i] <= r_wl[i-1];
        end
    end

    assign o_sched_word  = w;
    assign o_digest_word = r_h[i_word_sel];

endmodule

`default_nettype wire

// ===== hdl/sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one byte per cycle into the block while idle; o_ready is low
// while a full block is compressed (read setup, 64 rounds, fold) or padded.
// A last transfer is followed by padding and compression of one or two
// blocks, then eight digest transfers, one per cycle while i_ready is high.
// Rate is set by the single round unit and the schedule memory read ports.
// Reset (synchronous, active low) restores the initial hash and clears counts.
module sha256_stream_hasher_unit (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire s256h_pkg::t_in_item   i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output s256h_pkg::t_out_item       o_data
);
    import s256h_pkg::*;

    t_state       r_state, n_state;
    logic [5:0]   r_cnt, n_cnt;        // bytes pending in the block
    logic [54:0]  r_blk, n_blk;        // completed blocks (bit count / 512)
    logic [23:0]  r_pack, n_pack;      // last three bytes taken
    logic         r_fin, n_fin;        // message ends after this block
    logic         r_padding, n_padding;
    logic         r_two, n_two;        // padding spills into a second block
    logic         r_first, n_first;    // next padding word carries 0x80
    logic [3:0]   r_pidx, n_pidx;
    logic [5:0]   r_rnd, n_rnd;
    logic [2:0]   r_widx, n_widx;

    t_core_ctl          ctl;
    logic               we;
    logic [RamAw-1:0]   waddr, raddr_a, raddr_b;
    logic [WordW-1:0]   wdata, rdata_a, rdata_b, sched_word, digest_word, pad_word;
    logic [63:0]        msg_len;
    logic [5:0]         cnt_inc;

    s256h_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    s256h_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_round       (r_rnd),
        .i_rd_a        (rdata_a),
        .i_rd_b        (rdata_b),
        .i_word_sel    (r_widx),
        .o_sched_word  (sched_word),
        .o_digest_word (digest_word)
    );

    // Bit length: blocks, pending bytes, times eight
    assign msg_len = {r_blk, r_cnt, 3'b000};

    // Padding word for the current slot
    always_comb begin
        pad_word = '0;
        if (r_first) begin
            case (r_cnt[1:0])
                2'd0:    pad_word = {PadByte, 24'h0};
                2'd1:    pad_word = {r_pack[7:0], PadByte, 16'h0};
                2'd2:    pad_word = {r_pack[15:0], PadByte, 8'h0};
                default: pad_word = {r_pack[23:0], PadByte};
            endcase
        end else if (!r_two && r_pidx == LenHiSlot) begin
            pad_word = msg_len[63:32];
        end else if (!r_two && r_pidx == LastWordSlot) begin
            pad_word = msg_len[31:0];
        end
    end

    assign cnt_inc = i_data.has_byte ? r_cnt + 6'd1 : r_cnt;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_blk     <= '0;
            r_fin     <= 1'b0;
            r_padding <= 1'b0;
            r_two     <= 1'b0;
            r_first   <= 1'b0;
            r_pidx    <= '0;
            r_rnd     <= '0;
            r_widx    <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_blk     <= n_blk;
            r_fin     <= n_fin;
            r_padding <= n_padding;
            r_two     <= n_two;
            r_first   <= n_first;
            r_pidx    <= n_pidx;
            r_rnd     <= n_rnd;
            r_widx    <= n_widx;
        end
        r_pack <= n_pack;
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_blk     = r_blk;
        n_pack    = r_pack;
        n_fin     = r_fin;
        n_padding = r_padding;
        n_two     = r_two;
        n_first   = r_first;
        n_pidx    = r_pidx;
        n_rnd     = r_rnd;
        n_widx    = r_widx;
        ctl       = '0;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        raddr_a   = '0;
        raddr_b   = '0;
        o_ready   = 1'b0;
        o_valid   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_data.has_byte) begin
                        n_pack = {r_pack[15:0], i_data.data_byte};
                        n_cnt  = cnt_inc;
                        // Every fourth byte completes a big-endian word
                        if (r_cnt[1:0] == 2'd3) begin
                            we    = 1'b1;
                            waddr = r_cnt[5:2];
                            wdata = {r_pack, i_data.data_byte};
                        end
                    end
                    if (i_data.has_byte && r_cnt == LastByteSlot) begin
                        n_fin     = i_data.last;
                        n_padding = 1'b0;
                        n_state   = ST_CSTART;
                    end else if (i_data.last) begin
                        n_padding = 1'b1;
                        n_first   = 1'b1;
                        n_pidx    = cnt_inc[5:2];
                        n_two     = cnt_inc >= TwoBlockCount;
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                we      = 1'b1;
                waddr   = r_pidx;
                wdata   = pad_word;
                n_first = 1'b0;
                n_pidx  = r_pidx + 4'd1;
                if (r_pidx == LastWordSlot) begin
                    n_state = ST_CSTART;
                end
            end
            ST_CSTART: begin
                // Fetch the words for round zero
                ctl.load = 1'b1;
                raddr_a  = 4'd0;
                raddr_b  = 4'd1;
                n_rnd    = '0;
                n_state  = ST_ROUND;
            end
            ST_ROUND: begin
                ctl.step = 1'b1;
                we       = 1'b1;
                waddr    = r_rnd[3:0];
                wdata    = sched_word;
                raddr_a  = r_rnd[3:0] + 4'd1;
                raddr_b  = r_rnd[3:0] + 4'd2;
                n_rnd    = r_rnd + 6'd1;
                if (r_rnd == LastRound) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                if (r_padding) begin
                    if (r_two) begin
                        n_two   = 1'b0;
                        n_pidx  = '0;
                        n_first = 1'b0;
                        n_state = ST_PAD;
                    end else begin
                        n_widx  = '0;
                        n_state = ST_OUT;
                    end
                end else begin
                    n_blk = r_blk + 55'd1;
                    if (r_fin) begin
                        n_padding = 1'b1;
                        n_first   = 1'b1;
                        n_pidx    = '0;
                        n_two     = 1'b0;
                        n_state   = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == LastDigest) begin
                        ctl.init  = 1'b1;
                        n_cnt     = '0;
                        n_blk     = '0;
                        n_fin     = 1'b0;
                        n_padding = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Digest transfer payload
    always_comb begin
        o_data.digest_word = digest_word;
        o_data.word_index  = r_widx;
        o_data.last_word   = (r_widx == LastDigest);
    end

endmodule

`default_nettype wire
